// File: rtl/ntoa_pkg.sv
// shared types, constants and functions of the number to ascii formatter
package ntoa_pkg;

  localparam int unsigned CmdW   = 2;
  localparam int unsigned ValW   = 16;
  localparam int unsigned CharW  = 7;
  localparam int unsigned WeightW = 14;
  localparam int unsigned DigitW = 4;
  localparam int unsigned PosW   = 4;

  typedef enum logic [CmdW-1:0] {
    CMD_DEC = 2'd0,
    CMD_HEX = 2'd1,
    CMD_BIN = 2'd2,
    CMD_NONE = 2'd3
  } cmd_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_DIV,
    ST_LAST,
    ST_PUT
  } state_t;

  localparam logic [CharW-1:0] CH_ZERO = 7'h30;
  localparam logic [CharW-1:0] CH_ONE  = 7'h31;
  localparam logic [CharW-1:0] CH_A    = 7'h41;
  localparam logic [CharW-1:0] CH_F    = 7'h46;
  localparam logic [CharW-1:0] CH_B    = 7'h62;
  localparam logic [CharW-1:0] CH_X    = 7'h78;

  // last character index of the fixed-length formats
  localparam logic [PosW-1:0] HEX_LAST_POS = 4'd3;
  localparam logic [PosW-1:0] BIN_LAST_POS = 4'd8;

  function automatic logic [WeightW-1:0] dec_weight(input logic [1:0] idx);
    logic [WeightW-1:0] w;
    case (idx)
      2'd0:    w = 14'd10000;
      2'd1:    w = 14'd1000;
      2'd2:    w = 14'd100;
      default: w = 14'd10;
    endcase
    return w;
  endfunction

  function automatic logic [CharW-1:0] hex_char(input logic [3:0] nib);
    logic [CharW-1:0] c;
    if (nib > 4'd9) begin
      c = CH_A + {3'b000, nib - 4'd10};
    end else begin
      c = CH_ZERO + {3'b000, nib};
    end
    return c;
  endfunction

endpackage

// File: rtl/ntoa_sub_unit.sv
// shared compare and subtract unit for the decimal digit loop
module ntoa_sub_unit (
  input  logic [ntoa_pkg::ValW-1:0]    rem,
  input  logic [ntoa_pkg::WeightW-1:0] weight,
  output logic                         ge,
  output logic [ntoa_pkg::ValW-1:0]    diff
);

  logic [ntoa_pkg::ValW:0] sub;

  // borrow out of one wide subtract gives the compare
  assign sub  = {1'b0, rem} - {3'b000, weight};
  assign ge   = ~sub[ntoa_pkg::ValW];
  assign diff = sub[ntoa_pkg::ValW-1:0];

endmodule

// File: rtl/number_to_ascii_formatter_unit.sv
// number to ascii formatter: decimal, hex and binary text of one value
// first character comes from the put state in hex and binary mode and from the
//   digit loop in decimal; one character per cycle in hex and binary when not stalled
// a new item is taken only back in idle; item time is set by output stalls and, in
//   decimal mode, by the single compare and subtract unit doing one step a cycle
// synchronous active-low reset returns the sequencer to idle, output empty
module number_to_ascii_formatter_unit (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  output logic                          in_stall,
  input  logic [ntoa_pkg::CmdW-1:0]     in_command,
  input  logic [ntoa_pkg::ValW-1:0]     in_value,
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic [ntoa_pkg::CharW-1:0]    out_character,
  output logic                          out_last
);

  ntoa_pkg::state_t                  state_r, state_nxt;
  ntoa_pkg::cmd_t                    cmd_r, cmd_nxt;
  logic [ntoa_pkg::ValW-1:0]         rem_r, rem_nxt;
  logic [ntoa_pkg::DigitW-1:0]       digit_r, digit_nxt;
  logic [1:0]                        widx_r, widx_nxt;
  logic                              show_r, show_nxt;
  logic [ntoa_pkg::PosW-1:0]         pos_r, pos_nxt;
  logic                              out_valid_r, out_valid_nxt;
  logic [ntoa_pkg::CharW-1:0]        out_character_r, out_character_nxt;
  logic                              out_last_r, out_last_nxt;

  logic                              out_free;
  logic                              load;
  logic                              accept;
  logic                              ge;
  logic [ntoa_pkg::ValW-1:0]         diff;

  ntoa_sub_unit u_sub (
    .rem    (rem_r),
    .weight (ntoa_pkg::dec_weight(widx_r)),
    .ge     (ge),
    .diff   (diff)
  );

  assign out_free      = ~out_valid_r | ~out_stall;
  assign in_stall      = (state_r != ntoa_pkg::ST_IDLE);
  assign accept        = in_valid & ~in_stall;
  assign out_valid     = out_valid_r;
  assign out_character = out_character_r;
  assign out_last      = out_last_r;

  always_comb begin
    state_nxt         = state_r;
    cmd_nxt           = cmd_r;
    rem_nxt           = rem_r;
    digit_nxt         = digit_r;
    widx_nxt          = widx_r;
    show_nxt          = show_r;
    pos_nxt           = pos_r;
    load              = 1'b0;
    out_character_nxt = out_character_r;
    out_last_nxt      = out_last_r;

    case (state_r)
      ntoa_pkg::ST_IDLE: begin
        if (accept) begin
          cmd_nxt   = ntoa_pkg::cmd_t'(in_command);
          rem_nxt   = in_value;
          digit_nxt = '0;
          widx_nxt  = '0;
          show_nxt  = 1'b0;
          pos_nxt   = '0;
          case (ntoa_pkg::cmd_t'(in_command))
            ntoa_pkg::CMD_DEC:  state_nxt = ntoa_pkg::ST_DIV;
            ntoa_pkg::CMD_HEX:  state_nxt = ntoa_pkg::ST_PUT;
            ntoa_pkg::CMD_BIN:  state_nxt = ntoa_pkg::ST_PUT;
            default:            state_nxt = ntoa_pkg::ST_IDLE;
          endcase
        end
      end
      ntoa_pkg::ST_DIV: begin
        if (ge) begin
          rem_nxt   = diff;
          digit_nxt = digit_r + 4'd1;
        end else if ((digit_r == '0) && !show_r) begin
          // leading zero, skip it
          widx_nxt = widx_r + 2'd1;
          if (widx_r == 2'd3) begin
            state_nxt = ntoa_pkg::ST_LAST;
          end
        end else if (out_free) begin
          load              = 1'b1;
          out_character_nxt = ntoa_pkg::CH_ZERO + {3'b000, digit_r};
          out_last_nxt      = 1'b0;
          show_nxt          = 1'b1;
          digit_nxt         = '0;
          widx_nxt          = widx_r + 2'd1;
          if (widx_r == 2'd3) begin
            state_nxt = ntoa_pkg::ST_LAST;
          end
        end
      end
      ntoa_pkg::ST_LAST: begin
        if (out_free) begin
          load              = 1'b1;
          out_character_nxt = ntoa_pkg::CH_ZERO + {3'b000, rem_r[3:0]};
          out_last_nxt      = 1'b1;
          state_nxt         = ntoa_pkg::ST_IDLE;
        end
      end
      ntoa_pkg::ST_PUT: begin
        if (out_free) begin
          load    = 1'b1;
          pos_nxt = pos_r + 4'd1;
          if (cmd_r == ntoa_pkg::CMD_HEX) begin
            case (pos_r)
              4'd0:    out_character_nxt = ntoa_pkg::CH_ZERO;
              4'd1:    out_character_nxt = ntoa_pkg::CH_X;
              4'd2:    out_character_nxt = ntoa_pkg::hex_char(rem_r[7:4]);
              default: out_character_nxt = ntoa_pkg::hex_char(rem_r[3:0]);
            endcase
            out_last_nxt = (pos_r == ntoa_pkg::HEX_LAST_POS);
          end else begin
            if (pos_r == '0) begin
              out_character_nxt = ntoa_pkg::CH_B;
            end else begin
              // bits leave msb first as the byte shifts left
              out_character_nxt = rem_r[7] ? ntoa_pkg::CH_ONE : ntoa_pkg::CH_ZERO;
              rem_nxt = {rem_r[ntoa_pkg::ValW-2:0], 1'b0};
            end
            out_last_nxt = (pos_r == ntoa_pkg::BIN_LAST_POS);
          end
          if (out_last_nxt) begin
            state_nxt = ntoa_pkg::ST_IDLE;
          end
        end
      end
      default: begin
        state_nxt = ntoa_pkg::ST_IDLE;
      end
    endcase

    if (load) begin
      out_valid_nxt = 1'b1;
    end else begin
      out_valid_nxt = out_valid_r & out_stall;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ntoa_pkg::ST_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    cmd_r           <= cmd_nxt;
    rem_r           <= rem_nxt;
    digit_r         <= digit_nxt;
    widx_r          <= widx_nxt;
    show_r          <= show_nxt;
    pos_r           <= pos_nxt;
    out_character_r <= out_character_nxt;
    out_last_r      <= out_last_nxt;
  end

endmodule

// File: rtl/ntoa_checker.sv
// port-level checks of the number to ascii formatter and their binding
module ntoa_checker (
  input logic                       clk,
  input logic                       rst_n,
  input logic                       in_valid,
  input logic                       in_stall,
  input logic [ntoa_pkg::CmdW-1:0]  in_command,
  input logic                       out_valid,
  input logic                       out_stall,
  input logic [ntoa_pkg::CharW-1:0] out_character,
  input logic                       out_last
);

  // a stalled item holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_character) && $stable(out_last))
    else $error("stalled output item changed");

  // a formatting command keeps the block busy on the next cycle
  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall && (in_command != ntoa_pkg::CMD_NONE) |=> in_stall)
    else $error("block not busy after accepting an item");

  // when ready again, at most the final character is still waiting
  a_idle_only_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !in_stall |-> out_last)
    else $error("block ready while text still pending");

  // a final character is a digit or a hex letter
  a_last_char: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_last |-> (out_character >= ntoa_pkg::CH_ZERO) &&
      (out_character <= ntoa_pkg::CH_F))
    else $error("bad final character");

endmodule

bind number_to_ascii_formatter_unit ntoa_checker u_ntoa_checker (
  .clk           (clk),
  .rst_n         (rst_n),
  .in_valid      (in_valid),
  .in_stall      (in_stall),
  .in_command    (in_command),
  .out_valid     (out_valid),
  .out_stall     (out_stall),
  .out_character (out_character),
  .out_last      (out_last)
);

// File: tb/sv/tb_number_to_ascii_formatter_unit.sv
// self-checking testbench of the number to ascii formatter with random handshake idling
`timescale 1ns / 1ps

module tb_number_to_ascii_formatter_unit;
  import ntoa_pkg::*;

  typedef struct {
    cmd_t             command;
    logic [ValW-1:0]  value;
    int               gap;
    bit               drain_first;
  } fmt_request_t;

  typedef struct packed {
    logic [CharW-1:0] character;
    logic             last;
  } ascii_char_t;

  logic             clk = 1'b0;
  logic             rst_n = 1'b0;
  logic             in_valid = 1'b0;
  logic             in_stall;
  logic [CmdW-1:0]  in_command = CMD_DEC;
  logic [ValW-1:0]  in_value = '0;
  logic             out_valid;
  logic             out_stall = 1'b0;
  logic [CharW-1:0] out_character;
  logic             out_last;

  fmt_request_t requests_pending[$];
  ascii_char_t  chars_due[$];
  fmt_request_t next_req;
  ascii_char_t  want_char;
  bit           have_next = 1'b0;
  int           gap_left = 0;
  int           stall_left = 0;
  int           n_chars_seen = 0;
  int           n_errors = 0;

  number_to_ascii_formatter_unit u_dut (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_valid      (in_valid),
    .in_stall      (in_stall),
    .in_command    (in_command),
    .in_value      (in_value),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .out_character (out_character),
    .out_last      (out_last)
  );

  always #1 clk = ~clk;

  function automatic int pick_wait(input bit calm);
    if (calm || $urandom_range(0, 2) == 0) begin
      return 0;
    end
    return $urandom_range(0, 13);
  endfunction

  task automatic due_char(input logic [CharW-1:0] ch);
    ascii_char_t c;
    c.character = ch;
    c.last = 1'b0;
    chars_due.push_back(c);
  endtask

  // text of one value, appended to the characters still due
  task automatic format_value(input cmd_t command, input logic [ValW-1:0] value);
    int         base;
    int         rest;
    int         place;
    int         digit;
    bit         shown;
    logic [7:0] low_byte;
    logic [3:0] nib;
    base = chars_due.size();
    low_byte = value[7:0];
    case (command)
      CMD_DEC: begin
        rest = int'(value);
        shown = 1'b0;
        for (place = 10000; place >= 10; place = place / 10) begin
          digit = rest / place;
          rest = rest % place;
          // leading zeros are dropped
          if (digit != 0 || shown) begin
            shown = 1'b1;
            due_char(CH_ZERO + digit[CharW-1:0]);
          end
        end
        due_char(CH_ZERO + rest[CharW-1:0]);
      end
      CMD_HEX: begin
        due_char(CH_ZERO);
        due_char(CH_X);
        for (int k = 1; k >= 0; k--) begin
          nib = low_byte[k*4 +: 4];
          if (nib > 4'd9) begin
            due_char(CH_A + {3'b000, nib} - 7'd10);
          end else begin
            due_char(CH_ZERO + {3'b000, nib});
          end
        end
      end
      CMD_BIN: begin
        due_char(CH_B);
        for (int k = 7; k >= 0; k--) begin
          due_char(low_byte[k] ? CH_ONE : CH_ZERO);
        end
      end
      default: begin
      end
    endcase
    if (chars_due.size() > base) begin
      chars_due[chars_due.size() - 1].last = 1'b1;
    end
  endtask

  task automatic add_request(input cmd_t command, input logic [ValW-1:0] value,
                             input int gap, input bit drain_first);
    fmt_request_t r;
    r.command = command;
    r.value = value;
    r.gap = gap;
    r.drain_first = drain_first;
    requests_pending.push_back(r);
  endtask

  // driver
  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && !in_stall) begin
        format_value(cmd_t'(in_command), in_value);
      end
      if (!in_valid || !in_stall) begin
        if (!have_next && requests_pending.size() != 0) begin
          next_req = requests_pending.pop_front();
          gap_left = next_req.gap;
          have_next = 1'b1;
        end
        if (!have_next || (next_req.drain_first && chars_due.size() != 0)) begin
          in_valid <= 1'b0;
        end else if (gap_left > 0) begin
          gap_left--;
          in_valid <= 1'b0;
        end else begin
          in_valid <= 1'b1;
          in_command <= next_req.command;
          in_value <= next_req.value;
          have_next = 1'b0;
        end
      end
    end
  end

  // monitor and checker
  always @(posedge clk) begin
    if (!rst_n) begin
      out_stall <= 1'b0;
    end else begin
      if (out_valid && !out_stall) begin
        if (chars_due.size() == 0) begin
          $error("unexpected item: character %h last %b", out_character, out_last);
          n_errors++;
        end else begin
          want_char = chars_due.pop_front();
          if (out_character !== want_char.character) begin
            $error("character: expected %h, actual %h", want_char.character, out_character);
            n_errors++;
          end
          if (out_last !== want_char.last) begin
            $error("last: expected %b, actual %b", want_char.last, out_last);
            n_errors++;
          end
        end
        n_chars_seen++;
        // a stretch without stalls every so often
        stall_left = pick_wait((n_chars_seen / 150) % 5 == 2);
      end
      if (stall_left > 0) begin
        stall_left--;
        out_stall <= 1'b1;
      end else begin
        out_stall <= 1'b0;
      end
    end
  end

  initial begin
    #1_000_000;
    $display("DONE: errors detected");
    $finish;
  end

  initial begin
    int   n_random;
    int   pick;
    int   top;
    cmd_t command;
    logic [ValW-1:0] value;

    // directed: digit counts, zero, internal zeros, byte extremes, unused code
    add_request(CMD_DEC, 16'd0, 0, 1'b0);
    add_request(CMD_DEC, 16'd9, 0, 1'b0);
    add_request(CMD_DEC, 16'd10, pick_wait(1'b0), 1'b0);
    add_request(CMD_DEC, 16'd99, 0, 1'b0);
    add_request(CMD_DEC, 16'd100, pick_wait(1'b0), 1'b0);
    add_request(CMD_DEC, 16'd999, 0, 1'b0);
    add_request(CMD_DEC, 16'd1000, 0, 1'b0);
    add_request(CMD_DEC, 16'd9999, pick_wait(1'b0), 1'b0);
    add_request(CMD_DEC, 16'd10000, 0, 1'b0);
    add_request(CMD_DEC, 16'd10009, 0, 1'b0);
    add_request(CMD_DEC, 16'd65535, 0, 1'b0);
    add_request(CMD_HEX, 16'h0000, 0, 1'b1);
    add_request(CMD_HEX, 16'hFFFF, 0, 1'b0);
    add_request(CMD_HEX, 16'h12A5, pick_wait(1'b0), 1'b0);
    add_request(CMD_HEX, 16'h009F, 0, 1'b0);
    add_request(CMD_NONE, 16'hFFFF, 0, 1'b0);
    add_request(CMD_BIN, 16'h0000, 0, 1'b0);
    add_request(CMD_BIN, 16'hFFFF, 0, 1'b0);
    add_request(CMD_BIN, 16'h0080, pick_wait(1'b0), 1'b0);
    add_request(CMD_BIN, 16'hAA01, 0, 1'b0);
    add_request(CMD_NONE, 16'h0000, 0, 1'b0);
    add_request(CMD_DEC, 16'd60000, 0, 1'b1);

    n_random = 0;
    while (n_random < 308) begin
      pick = $urandom_range(0, 19);
      value = ValW'($urandom_range(0, 65535));
      if (pick < 9) begin
        command = CMD_DEC;
        // spread decimal values over all digit counts
        case ($urandom_range(0, 4))
          0:       top = 9;
          1:       top = 99;
          2:       top = 999;
          3:       top = 9999;
          default: top = 65535;
        endcase
        value = ValW'($urandom_range(0, top));
      end else if (pick < 13) begin
        command = CMD_HEX;
      end else if (pick < 18) begin
        command = CMD_BIN;
      end else begin
        command = CMD_NONE;
      end
      add_request(command, value, pick_wait(n_random >= 120 && n_random < 170),
                  $urandom_range(0, 29) == 0);
      if (command != CMD_NONE) begin
        n_random++;
      end
    end

    repeat (10) @(posedge clk);
    rst_n <= 1'b1;

    while (requests_pending.size() != 0 || have_next || in_valid || chars_due.size() != 0) begin
      @(posedge clk);
    end
    repeat (80) @(posedge clk);

    if (chars_due.size() != 0) begin
      $error("%0d expected characters never arrived", chars_due.size());
      n_errors++;
    end
    if (n_errors == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule
